>>> rtl/core/lic_pkg.sv
// package: shared types, codes and field helpers of the eight-channel input qualifier
`timescale 1ns / 1ps
package lic_pkg;

  // channel count
  localparam int NumChannels = 8;
  localparam int MaxChannels = 8;

  // config port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_MODES         = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_HEADS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_HEADS  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TURNOUT_PINS  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SET_DELAY     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CLEAR_DELAY   = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_TURNOUT_DELAY = 3'd6;

  // channel mode codes
  localparam logic [3:0] MODE_UNUSED   = 4'd0;
  localparam logic [3:0] MODE_CAPTURE  = 4'd1;
  localparam logic [3:0] MODE_TCAPTURE = 4'd2;
  localparam logic [3:0] MODE_RELEASE  = 4'd3;
  localparam logic [3:0] MODE_TURNOUT  = 4'd4;
  localparam logic [3:0] MODE_OVL_G    = 4'd5;
  localparam logic [3:0] MODE_OVL_A    = 4'd6;
  localparam logic [3:0] MODE_OVL_R    = 4'd7;
  localparam logic [3:0] MODE_AUX      = 4'd8;

  localparam logic [15:0] HoldMax = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_POLL  = 2'd0,
    OP_FORCE = 2'd1,
    OP_ACK   = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    RK_EVENT  = 2'd0,
    RK_STATUS = 2'd1,
    RK_ANSWER = 2'd2,
    RK_DONE   = 2'd3
  } result_kind_e;

  // configuration registers
  typedef struct packed {
    logic [31:0] modes;
    logic [63:0] first_heads;
    logic [63:0] second_heads;
    logic [23:0] turnout_pins;
    logic [15:0] set_delay;
    logic [15:0] clear_delay;
    logic [15:0] turnout_delay;
  } cfg_regs_t;

  localparam cfg_regs_t CfgReset = '{
    modes:         32'd0,
    first_heads:   {64{1'b1}},
    second_heads:  {64{1'b1}},
    turnout_pins:  24'd0,
    set_delay:     16'd5,
    clear_delay:   16'd500,
    turnout_delay: 16'd50
  };

  // per-lane view of the configuration
  typedef struct packed {
    logic [3:0] mode;
    logic [7:0] head1;
    logic [7:0] head2;
    logic [2:0] pin;
  } lane_cfg_t;

  typedef struct packed {
    logic [15:0] set_delay;
    logic [15:0] clear_delay;
    logic [15:0] turnout_delay;
  } dly_t;

  // item fields shared by all lanes
  typedef struct packed {
    opcode_e    op;
    logic [7:0] elapsed;
    logic [7:0] head;
    logic [3:0] kind;
  } cmd_t;

  // per-channel state
  typedef struct packed {
    logic        act;
    logic        ack;
    logic        prev;
    logic [15:0] hold;
  } lane_st_t;

  typedef struct packed {
    lane_st_t st;
    logic     fire;
    logic     chg;
    logic     hit;
  } lane_res_t;

  // item handed from the lanes to the merge stage
  typedef struct packed {
    logic [MaxChannels-1:0] fire;
    logic [MaxChannels-1:0] act_old;
    logic [MaxChannels-1:0] act_new;
    result_kind_e           kind;
    logic [7:0]             mask;
    logic [7:0]             aux;
    logic                   changed;
    logic                   answer;
  } pend_t;

  function automatic logic [3:0] ch_mode(input logic [31:0] modes, input logic [2:0] ch);
    return modes[{ch, 2'b00} +: 4];
  endfunction

  function automatic logic [7:0] ch_head(input logic [63:0] heads, input logic [2:0] ch);
    return heads[{ch, 3'b000} +: 8];
  endfunction

  function automatic logic [2:0] ch_pin(input logic [23:0] pins, input logic [2:0] ch);
    return pins[5'(ch) * 5'd3 +: 3];
  endfunction

endpackage

>>> rtl/core/lic_if.sv
// interfaces: input, result and config channels
`timescale 1ns / 1ps
interface lic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] raw_pins;
  logic [7:0] elapsed_ms;
  logic [7:0] head;
  logic [3:0] kind;

  modport source (output valid, opcode, raw_pins, elapsed_ms, head, kind, input ready);
  modport sink   (input valid, opcode, raw_pins, elapsed_ms, head, kind, output ready);
endinterface

interface lic_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] event_head;
  logic [7:0] active_mask;
  logic [7:0] aux_bits;
  logic       changed;
  logic       answer;
  logic       last;

  modport source (output valid, result_kind, event_head, active_mask, aux_bits, changed,
                  answer, last, input ready);
  modport sink   (input valid, result_kind, event_head, active_mask, aux_bits, changed,
                  answer, last, output ready);
endinterface

interface lic_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/lic_lane.sv
// one channel lane: hold timer, latch update, force/acknowledge/query match
`timescale 1ns / 1ps
module lic_lane import lic_pkg::*; #(
  parameter int CHANNELS = NumChannels
) (
  input  cmd_t                   cmd_i,
  input  logic                   raw_i,
  input  lane_cfg_t              cfg_i,
  input  dly_t                   dly_i,
  input  logic [MaxChannels-1:0] act_all_i,
  input  lane_st_t               st_i,
  output lane_res_t              res_o
);

  logic [16:0] sum;
  logic [15:0] hold_nx;
  logic        pin_act;
  logic        match;

  // saturating hold timer, restarted on a level change
  always_comb begin
    sum = {1'b0, st_i.hold} + 17'(cmd_i.elapsed);
    if (raw_i != st_i.prev) begin
      hold_nx = '0;
    end else if (sum[16]) begin
      hold_nx = HoldMax;
    end else begin
      hold_nx = sum[15:0];
    end
  end

  // turnout position from another channel, out-of-range pins read inactive
  assign pin_act = ({1'b0, cfg_i.pin} < 4'(CHANNELS)) && act_all_i[cfg_i.pin];

  // query match for this channel
  always_comb begin
    match = 1'b0;
    if (cmd_i.kind == MODE_CAPTURE || cmd_i.kind == MODE_TCAPTURE) begin
      if (cfg_i.mode == MODE_CAPTURE && cfg_i.head1 == cmd_i.head) match = 1'b1;
      if (cfg_i.mode == MODE_TCAPTURE &&
          ((cfg_i.head1 == cmd_i.head && !pin_act) ||
           (cfg_i.head2 == cmd_i.head && pin_act))) match = 1'b1;
    end else if (cmd_i.kind == MODE_RELEASE || cmd_i.kind == MODE_OVL_G ||
                 cmd_i.kind == MODE_OVL_A || cmd_i.kind == MODE_OVL_R) begin
      if (cfg_i.mode == cmd_i.kind && cfg_i.head1 == cmd_i.head) match = 1'b1;
    end
  end

  // next state per opcode
  always_comb begin
    res_o.st   = st_i;
    res_o.fire = 1'b0;
    res_o.chg  = 1'b0;
    res_o.hit  = 1'b0;
    unique case (cmd_i.op)
      OP_POLL: begin
        res_o.st.hold = hold_nx;
        res_o.st.prev = raw_i;
        case (cfg_i.mode) inside
          MODE_CAPTURE, MODE_TCAPTURE, MODE_RELEASE: begin
            if (st_i.ack && !raw_i && hold_nx > dly_i.clear_delay) begin
              res_o.st.act = 1'b0;
              res_o.st.ack = 1'b0;
            end else if (!st_i.act && raw_i && hold_nx > dly_i.set_delay) begin
              res_o.st.act = 1'b1;
              res_o.fire   = 1'b1;
            end
          end
          [MODE_TURNOUT:MODE_AUX]: begin
            if (st_i.act != raw_i && hold_nx > dly_i.turnout_delay) begin
              res_o.st.act = raw_i;
              res_o.chg    = 1'b1;
            end
          end
          MODE_UNUSED: res_o.st.act = raw_i;
          default: ;
        endcase
      end
      OP_FORCE: begin
        if (((cmd_i.kind == MODE_CAPTURE || cmd_i.kind == MODE_TCAPTURE) &&
             (cfg_i.mode == MODE_CAPTURE || cfg_i.mode == MODE_TCAPTURE) &&
             cfg_i.head1 == cmd_i.head) ||
            (cmd_i.kind == MODE_RELEASE && cfg_i.mode == MODE_RELEASE &&
             cfg_i.head1 == cmd_i.head)) begin
          res_o.st.act = 1'b1;
          res_o.st.ack = 1'b0;
        end
      end
      OP_ACK: begin
        if (cfg_i.mode == cmd_i.kind &&
            (cfg_i.head1 == cmd_i.head ||
             (cmd_i.kind == MODE_TCAPTURE && cfg_i.head2 == cmd_i.head))) begin
          res_o.st.ack = 1'b1;
        end
      end
      OP_QUERY: res_o.hit = match && st_i.act && !st_i.ack;
      default: ;
    endcase
  end

endmodule

>>> rtl/core/lic_merge.sv
// merge stage: start events in channel order, then the closing result
`timescale 1ns / 1ps
module lic_merge import lic_pkg::*; #(
  parameter int CHANNELS = NumChannels
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  pend_t      pend_i,
  input  cfg_regs_t  cfg_i,
  output logic       ready_o,
  lic_out_if.source  out_o
);

  logic         pend_valid_q, pend_valid_d;
  pend_t        pend_q, pend_d;
  logic         out_valid_q, out_valid_d;
  result_kind_e out_kind_q, out_kind_d;
  logic [7:0]   out_head_q, out_head_d;
  logic [7:0]   out_mask_q, out_mask_d;
  logic [7:0]   out_aux_q, out_aux_d;
  logic         out_chg_q, out_chg_d;
  logic         out_ans_q, out_ans_d;
  logic         out_last_q, out_last_d;

  logic       out_free;
  logic       found;
  logic [2:0] sel;
  logic [2:0] sel_pin;
  logic       sel_pin_act;
  logic [7:0] sel_head;

  assign ready_o  = !pend_valid_q;
  assign out_free = !out_valid_q || out_o.ready;

  // lowest channel with a pending start event
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (pend_q.fire[i]) begin
        found = 1'b1;
        sel   = 3'(i);
      end
    end
  end

  // turnout pin as seen right after this channel latched
  always_comb begin
    sel_pin     = ch_pin(cfg_i.turnout_pins, sel);
    sel_pin_act = ({1'b0, sel_pin} < 4'(CHANNELS)) &&
                  ((sel_pin <= sel) ? pend_q.act_new[sel_pin] : pend_q.act_old[sel_pin]);
    if (ch_mode(cfg_i.modes, sel) == MODE_TCAPTURE && sel_pin_act) begin
      sel_head = ch_head(cfg_i.second_heads, sel);
    end else begin
      sel_head = ch_head(cfg_i.first_heads, sel);
    end
  end

  // pick the next result into the output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_kind_d   = out_kind_q;
    out_head_d   = out_head_q;
    out_mask_d   = out_mask_q;
    out_aux_d    = out_aux_q;
    out_chg_d    = out_chg_q;
    out_ans_d    = out_ans_q;
    out_last_d   = out_last_q;
    if (load_i) begin
      pend_valid_d = 1'b1;
      pend_d       = pend_i;
    end
    if (out_free) begin
      out_valid_d = 1'b0;
      if (pend_valid_q) begin
        out_valid_d = 1'b1;
        if (found) begin
          out_kind_d       = RK_EVENT;
          out_head_d       = sel_head;
          out_mask_d       = '0;
          out_aux_d        = '0;
          out_chg_d        = 1'b0;
          out_ans_d        = 1'b0;
          out_last_d       = 1'b0;
          pend_d.fire[sel] = 1'b0;
        end else begin
          out_kind_d   = pend_q.kind;
          out_head_d   = '0;
          out_mask_d   = pend_q.mask;
          out_aux_d    = pend_q.aux;
          out_chg_d    = pend_q.changed;
          out_ans_d    = pend_q.answer;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_kind_q <= out_kind_d;
    out_head_q <= out_head_d;
    out_mask_q <= out_mask_d;
    out_aux_q  <= out_aux_d;
    out_chg_q  <= out_chg_d;
    out_ans_q  <= out_ans_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_kind = out_kind_q;
  assign out_o.event_head  = out_head_q;
  assign out_o.active_mask = out_mask_q;
  assign out_o.aux_bits    = out_aux_q;
  assign out_o.changed     = out_chg_q;
  assign out_o.answer      = out_ans_q;
  assign out_o.last        = out_last_q;

endmodule

>>> rtl/core/latched_input_qualifier_8ch.sv
// top level: config registers, channel state, lanes and merge stage
//
// channel | dir | handshake     | payload
// in_i    | in  | valid / ready | opcode, raw_pins, elapsed_ms, head, kind
// out_o   | out | valid / ready | result_kind, event_head, active_mask, aux_bits,
//         |     |               | changed, answer, last
// cfg_i   | in  | valid / ready | index, data (always ready)
//
// all channels are evaluated by parallel lanes in the cycle an item is taken
// the merge stage then sends one result per cycle while the output is not stalled: k start
// events plus one closing result, so an item gives 1 to CHANNELS+1 results at the output
// in_i.ready returns once the closing result of the item enters the output register
// reset restores the default config and clears latches, acks and hold timers
// a stalled output holds the output register and the merge stage
`timescale 1ns / 1ps
module latched_input_qualifier_8ch import lic_pkg::*; #(
  parameter int CHANNELS = NumChannels
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lic_in_if.sink   in_i,
  lic_out_if.source out_o,
  lic_cfg_if.sink  cfg_i
);

  cfg_regs_t              cfg_q;
  lane_st_t               st_q [CHANNELS];
  lane_res_t              res  [CHANNELS];
  lane_cfg_t              lane_cfg [CHANNELS];
  cmd_t                   cmd;
  dly_t                   dly;
  logic [MaxChannels-1:0] act_old, act_new, fire;
  logic                   any_chg, any_hit;
  logic [7:0]             aux;
  logic [2:0]             aux_pos;
  logic                   accept;
  logic                   merge_ready;
  pend_t                  pend;

  assign accept = in_i.valid && merge_ready;
  assign in_i.ready = merge_ready;

  // config writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_MODES:         cfg_q.modes         <= cfg_i.data[31:0];
        CFG_FIRST_HEADS:   cfg_q.first_heads   <= cfg_i.data;
        CFG_SECOND_HEADS:  cfg_q.second_heads  <= cfg_i.data;
        CFG_TURNOUT_PINS:  cfg_q.turnout_pins  <= cfg_i.data[23:0];
        CFG_SET_DELAY:     cfg_q.set_delay     <= cfg_i.data[15:0];
        CFG_CLEAR_DELAY:   cfg_q.clear_delay   <= cfg_i.data[15:0];
        CFG_TURNOUT_DELAY: cfg_q.turnout_delay <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // fields common to all lanes
  assign cmd = '{op: opcode_e'(in_i.opcode), elapsed: in_i.elapsed_ms,
                 head: in_i.head, kind: in_i.kind};
  assign dly = '{set_delay: cfg_q.set_delay, clear_delay: cfg_q.clear_delay,
                 turnout_delay: cfg_q.turnout_delay};

  // channel lanes
  for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
    assign lane_cfg[g] = '{mode:  ch_mode(cfg_q.modes, 3'(g)),
                           head1: ch_head(cfg_q.first_heads, 3'(g)),
                           head2: ch_head(cfg_q.second_heads, 3'(g)),
                           pin:   ch_pin(cfg_q.turnout_pins, 3'(g))};

    lic_lane #(.CHANNELS(CHANNELS)) u_lane (
      .cmd_i     (cmd),
      .raw_i     (in_i.raw_pins[g]),
      .cfg_i     (lane_cfg[g]),
      .dly_i     (dly),
      .act_all_i (act_old),
      .st_i      (st_q[g]),
      .res_o     (res[g])
    );
  end

  // gather lane results
  always_comb begin
    act_old = '0;
    act_new = '0;
    fire    = '0;
    any_chg = 1'b0;
    any_hit = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      act_old[i] = st_q[i].act;
      act_new[i] = res[i].st.act;
      fire[i]    = res[i].fire;
      any_chg    = any_chg | res[i].chg;
      any_hit    = any_hit | res[i].hit;
    end
  end

  // aux levels packed in channel order
  always_comb begin
    aux     = '0;
    aux_pos = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (lane_cfg[i].mode == MODE_AUX) begin
        aux[aux_pos] = act_new[i];
        aux_pos      = aux_pos + 3'd1;
      end
    end
  end

  // item summary for the merge stage
  always_comb begin
    pend.fire    = fire;
    pend.act_old = act_old;
    pend.act_new = act_new;
    pend.mask    = act_new;
    pend.aux     = aux;
    pend.changed = 1'b0;
    pend.answer  = 1'b0;
    unique case (cmd.op)
      OP_POLL: begin
        pend.kind    = RK_STATUS;
        pend.changed = any_chg;
      end
      OP_QUERY: begin
        pend.kind   = RK_ANSWER;
        pend.answer = any_hit;
      end
      default: pend.kind = RK_DONE;
    endcase
  end

  // channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_q[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_q[i] <= res[i].st;
      end
    end
  end

  lic_merge #(.CHANNELS(CHANNELS)) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (accept),
    .pend_i  (pend),
    .cfg_i   (cfg_q),
    .ready_o (merge_ready),
    .out_o   (out_o)
  );

endmodule

>>> rtl/core/lic_checker.sv
// checker on the top-level ports, bound to the top level
`timescale 1ns / 1ps
module lic_checker import lic_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [1:0] out_kind_i,
  input logic [7:0] out_head_i,
  input logic [7:0] out_mask_i,
  input logic [7:0] out_aux_i,
  input logic       out_chg_i,
  input logic       out_ans_i,
  input logic       out_last_i
);

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i &&
      $stable({out_kind_i, out_head_i, out_mask_i, out_aux_i, out_chg_i, out_ans_i,
               out_last_i}))
    else $error("result changed while stalled");

  // only start events are non-final
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((out_kind_i == RK_EVENT) != out_last_i))
    else $error("last flag does not match result kind");

  // start events carry only a head
  a_event_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == RK_EVENT |->
      out_mask_i == 8'd0 && out_aux_i == 8'd0 && !out_chg_i && !out_ans_i)
    else $error("start event carries status fields");

  // one transaction in flight on the input side
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken again before item was drained");

  // changed flag only on poll status
  a_chg_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i != RK_STATUS |-> !out_chg_i)
    else $error("changed flag outside poll status");

endmodule

bind latched_input_qualifier_8ch lic_checker u_lic_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.result_kind),
  .out_head_i  (out_o.event_head),
  .out_mask_i  (out_o.active_mask),
  .out_aux_i   (out_o.aux_bits),
  .out_chg_i   (out_o.changed),
  .out_ans_i   (out_o.answer),
  .out_last_i  (out_o.last)
);

>>> verif/lic_tb_pkg.sv
// scoreboard package: transaction types and the latch-tracking scoreboard class
`timescale 1ns / 1ps
package lic_tb_pkg;
  import lic_pkg::*;

  // one input transaction
  typedef struct {
    opcode_e    op;
    logic [7:0] raw;
    logic [7:0] elapsed;
    logic [7:0] head;
    logic [3:0] kind;
  } qual_item_t;

  // one result transaction
  typedef struct {
    result_kind_e rk;
    logic [7:0]   ev_head;
    logic [7:0]   mask;
    logic [7:0]   aux;
    logic         changed;
    logic         answer;
    logic         last;
  } qual_result_t;

  class latch_tracker;
    // shadow of the configuration registers
    logic [31:0] modes;
    logic [63:0] heads1;
    logic [63:0] heads2;
    logic [23:0] pins;
    logic [15:0] set_dly;
    logic [15:0] clr_dly;
    logic [15:0] to_dly;

    // shadow of the channel state
    logic [7:0]  act;
    logic [7:0]  ackd;
    logic [7:0]  prev_raw;
    logic [15:0] hold [NumChannels];

    qual_result_t due_results [$];
    int errors;

    function new();
      errors = 0;
      reset_state();
    endfunction

    function void reset_state();
      modes    = CfgReset.modes;
      heads1   = CfgReset.first_heads;
      heads2   = CfgReset.second_heads;
      pins     = CfgReset.turnout_pins;
      set_dly  = CfgReset.set_delay;
      clr_dly  = CfgReset.clear_delay;
      to_dly   = CfgReset.turnout_delay;
      act      = '0;
      ackd     = '0;
      prev_raw = '0;
      for (int i = 0; i < NumChannels; i++) hold[i] = '0;
      due_results.delete();
    endfunction

    function logic [3:0] mode_at(int i);
      return modes[4*i +: 4];
    endfunction

    function logic [7:0] head1_at(int i);
      return heads1[8*i +: 8];
    endfunction

    function logic [7:0] head2_at(int i);
      return heads2[8*i +: 8];
    endfunction

    // turnout position of a channel, out-of-range pins read inactive
    function logic pin_on(int i);
      logic [2:0] p;
      p = pins[3*i +: 3];
      if (int'(p) >= NumChannels) return 1'b0;
      return act[p];
    endfunction

    // aux channel levels packed in channel order
    function logic [7:0] aux_packed();
      logic [7:0] r;
      int pos;
      r = '0;
      pos = 0;
      for (int i = 0; i < NumChannels; i++) begin
        if (mode_at(i) == MODE_AUX) begin
          r[pos] = act[i];
          pos++;
        end
      end
      return r;
    endfunction

    function void push_result(result_kind_e rk, logic [7:0] hd, logic [7:0] mask,
                              logic [7:0] aux, logic chg, logic ans, logic lst);
      qual_result_t res;
      res.rk      = rk;
      res.ev_head = hd;
      res.mask    = mask;
      res.aux     = aux;
      res.changed = chg;
      res.answer  = ans;
      res.last    = lst;
      due_results.push_back(res);
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] d);
      case (idx)
        CFG_MODES:         modes   = d[31:0];
        CFG_FIRST_HEADS:   heads1  = d;
        CFG_SECOND_HEADS:  heads2  = d;
        CFG_TURNOUT_PINS:  pins    = d[23:0];
        CFG_SET_DELAY:     set_dly = d[15:0];
        CFG_CLEAR_DELAY:   clr_dly = d[15:0];
        CFG_TURNOUT_DELAY: to_dly  = d[15:0];
        default: ;
      endcase
    endfunction

    // poll: walk channels in index order, events first then the status
    function void run_poll(logic [7:0] raw_all, logic [7:0] el);
      logic chg;
      logic r;
      logic a;
      logic k;
      logic [3:0] m;
      logic [7:0] eh;
      int h;
      chg = 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        r = raw_all[i];
        a = act[i];
        k = ackd[i];
        m = mode_at(i);
        if (r != prev_raw[i]) begin
          h = 0;
        end else begin
          h = int'(hold[i]) + int'(el);
          if (h > int'(HoldMax)) h = int'(HoldMax);
        end
        hold[i] = 16'(h);
        prev_raw[i] = r;
        if (m == MODE_CAPTURE || m == MODE_TCAPTURE || m == MODE_RELEASE) begin
          if (k && !r && h > int'(clr_dly)) begin
            act[i]  = 1'b0;
            ackd[i] = 1'b0;
          end else if (!a && r && h > int'(set_dly)) begin
            act[i] = 1'b1;
            eh = (m == MODE_TCAPTURE && pin_on(i)) ? head2_at(i) : head1_at(i);
            push_result(RK_EVENT, eh, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
          end
        end else if (m >= MODE_TURNOUT && m <= MODE_AUX) begin
          if (a != r && h > int'(to_dly)) begin
            act[i] = r;
            chg = 1'b1;
          end
        end else if (m == MODE_UNUSED) begin
          act[i] = r;
        end
      end
      push_result(RK_STATUS, 8'h00, act, aux_packed(), chg, 1'b0, 1'b1);
    endfunction

    // force latches of matching capture or release channels
    function void run_force(logic [7:0] hd, logic [3:0] kd);
      logic [3:0] m;
      for (int i = 0; i < NumChannels; i++) begin
        m = mode_at(i);
        if (((kd == MODE_CAPTURE || kd == MODE_TCAPTURE) &&
             (m == MODE_CAPTURE || m == MODE_TCAPTURE) && head1_at(i) == hd) ||
            (kd == MODE_RELEASE && m == MODE_RELEASE && head1_at(i) == hd)) begin
          act[i]  = 1'b1;
          ackd[i] = 1'b0;
        end
      end
      push_result(RK_DONE, 8'h00, act, aux_packed(), 1'b0, 1'b0, 1'b1);
    endfunction

    // acknowledge channels of the given mode by primary head, or by second head for tcapture
    function void run_ack(logic [7:0] hd, logic [3:0] kd);
      for (int i = 0; i < NumChannels; i++) begin
        if (mode_at(i) == kd &&
            (head1_at(i) == hd || (kd == MODE_TCAPTURE && head2_at(i) == hd)))
          ackd[i] = 1'b1;
      end
      push_result(RK_DONE, 8'h00, act, aux_packed(), 1'b0, 1'b0, 1'b1);
    endfunction

    // query: any matching channel active and not acknowledged
    function void run_query(logic [7:0] hd, logic [3:0] kd);
      logic ans;
      logic hit;
      logic tp;
      logic [3:0] m;
      ans = 1'b0;
      for (int i = 0; i < NumChannels; i++) begin
        m = mode_at(i);
        hit = 1'b0;
        if (kd == MODE_CAPTURE || kd == MODE_TCAPTURE) begin
          if (m == MODE_CAPTURE && head1_at(i) == hd) hit = 1'b1;
          if (m == MODE_TCAPTURE) begin
            tp = pin_on(i);
            if ((head1_at(i) == hd && !tp) || (head2_at(i) == hd && tp)) hit = 1'b1;
          end
        end else if (kd == MODE_RELEASE || kd == MODE_OVL_G || kd == MODE_OVL_A ||
                     kd == MODE_OVL_R) begin
          if (m == kd && head1_at(i) == hd) hit = 1'b1;
        end
        if (hit && act[i] && !ackd[i]) ans = 1'b1;
      end
      push_result(RK_ANSWER, 8'h00, act, aux_packed(), 1'b0, ans, 1'b1);
    endfunction

    // note an accepted input transaction
    function void take_item(qual_item_t it);
      case (it.op)
        OP_POLL:  run_poll(it.raw, it.elapsed);
        OP_FORCE: run_force(it.head, it.kind);
        OP_ACK:   run_ack(it.head, it.kind);
        default:  run_query(it.head, it.kind);
      endcase
    endfunction

    task report(string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // compare an accepted result with the oldest expectation
    task match_result(qual_result_t got);
      qual_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result kind %0d with nothing expected", got.rk));
        return;
      end
      want = due_results.pop_front();
      check_field("result_kind", 8'(got.rk), 8'(want.rk));
      check_field("event_head", got.ev_head, want.ev_head);
      check_field("active_mask", got.mask, want.mask);
      check_field("aux_bits", got.aux, want.aux);
      check_field("changed", 8'(got.changed), 8'(want.changed));
      check_field("answer", 8'(got.answer), 8'(want.answer));
      check_field("last", 8'(got.last), 8'(want.last));
    endtask
  endclass

endpackage

>>> verif/tb.sv
// testbench top: drives the qualifier, tracks latches and checks every result
`timescale 1ns / 1ps
module tb;
  import lic_pkg::*;
  import lic_tb_pkg::*;

  localparam int IdleLimit = 2000;

  logic clk;
  logic rst_n;

  lic_in_if  in_if ();
  lic_out_if out_if ();
  lic_cfg_if cfg_if ();

  latched_input_qualifier_8ch dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  latch_tracker sb;
  bit           quiet;
  logic [7:0]   raw_level;
  int           idle_cycles;
  qual_item_t   mon_item;
  qual_result_t mon_res;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // per-transaction wait, zero during quiet stretches
  function automatic int draw_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 1) == 1) ? int'($urandom_range(0, 18)) : 0;
  endfunction

  function automatic logic [7:0] pick_head();
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'h81;
      2:       return 8'h7E;
      3:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [3:0] pick_kind();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(0, 8));
  endfunction

  function automatic logic [7:0] pick_elapsed();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 3));
      1:       return 8'($urandom_range(0, 20));
      2:       return 8'($urandom_range(0, 255));
      default: return 8'hFF;
    endcase
  endfunction

  // present one input transaction and wait for it to be taken
  task automatic send_item(opcode_e op, logic [7:0] raw, logic [7:0] el, logic [7:0] hd,
                           logic [3:0] kd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.opcode     <= op;
    in_if.raw_pins   <= raw;
    in_if.elapsed_ms <= el;
    in_if.head       <= hd;
    in_if.kind       <= kd;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  // stop sending and wait until every expected result has come
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
  endtask

  // write every register back to back
  task automatic load_config(logic [31:0] md, logic [63:0] h1, logic [63:0] h2,
                             logic [23:0] pn, logic [15:0] sd, logic [15:0] cd,
                             logic [15:0] td);
    write_reg(CFG_MODES, 64'(md));
    write_reg(CFG_FIRST_HEADS, h1);
    write_reg(CFG_SECOND_HEADS, h2);
    write_reg(CFG_TURNOUT_PINS, 64'(pn));
    write_reg(CFG_SET_DELAY, 64'(sd));
    write_reg(CFG_CLEAR_DELAY, 64'(cd));
    write_reg(CFG_TURNOUT_DELAY, 64'(td));
    cfg_if.valid <= 1'b0;
  endtask

  // random configuration, then mostly slowly changing polls mixed with commands
  task automatic random_phase(int n, int dly_style, bit cap_heavy);
    logic [31:0] md;
    logic [63:0] h1;
    logic [63:0] h2;
    logic [15:0] sd;
    logic [15:0] cd;
    logic [15:0] td;
    logic [7:0]  flip;
    int          r;
    for (int i = 0; i < NumChannels; i++) begin
      if (cap_heavy) md[4*i +: 4] = 4'($urandom_range(1, 3));
      else if ($urandom_range(0, 9) == 0) md[4*i +: 4] = 4'($urandom_range(9, 15));
      else md[4*i +: 4] = 4'($urandom_range(0, 8));
      h1[8*i +: 8] = pick_head();
      h2[8*i +: 8] = pick_head();
    end
    case (dly_style)
      0: begin
        sd = 16'h0000;
        cd = 16'h0000;
        td = 16'h0000;
      end
      1: begin
        sd = 16'hFFFF;
        cd = 16'hFFFF;
        td = 16'hFFFF;
      end
      default: begin
        sd = 16'($urandom_range(0, 30));
        cd = 16'($urandom_range(0, 300));
        td = 16'($urandom_range(0, 100));
      end
    endcase
    load_config(md, h1, h2, 24'($urandom()), sd, cd, td);
    for (int k = 0; k < n; k++) begin
      // sender holds off once per phase until the output side is empty
      if (k == n / 2) drain();
      r = $urandom_range(0, 9);
      if (r < 6) begin
        flip = '0;
        for (int j = 0; j < NumChannels; j++) flip[j] = ($urandom_range(0, 4) == 0);
        raw_level = raw_level ^ flip;
        send_item(OP_POLL, raw_level, pick_elapsed(), 8'($urandom()), 4'($urandom()));
      end else begin
        send_item((r == 6) ? OP_FORCE : ((r == 7) ? OP_ACK : OP_QUERY), 8'($urandom()),
                  8'($urandom()), pick_head(), pick_kind());
      end
    end
    drain();
  endtask

  // transaction monitor feeding the scoreboard
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        mon_item.op      = opcode_e'(in_if.opcode);
        mon_item.raw     = in_if.raw_pins;
        mon_item.elapsed = in_if.elapsed_ms;
        mon_item.head    = in_if.head;
        mon_item.kind    = in_if.kind;
        sb.take_item(mon_item);
      end
      if (out_if.valid && out_if.ready) begin
        mon_res.rk      = result_kind_e'(out_if.result_kind);
        mon_res.ev_head = out_if.event_head;
        mon_res.mask    = out_if.active_mask;
        mon_res.aux     = out_if.aux_bits;
        mon_res.changed = out_if.changed;
        mon_res.answer  = out_if.answer;
        mon_res.last    = out_if.last;
        sb.match_result(mon_res);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("latched_input_qualifier_8ch test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side ready with random stalls
  initial begin : result_sink
    int gap;
    out_if.ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // stimulus
  initial begin
    sb = new();
    quiet = 1'b0;
    raw_level = 8'h00;
    rst_n            <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.opcode     <= OP_POLL;
    in_if.raw_pins   <= 8'h00;
    in_if.elapsed_ms <= 8'h00;
    in_if.head       <= 8'h00;
    in_if.kind       <= 4'h0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= CFG_MODES;
    cfg_if.data      <= 64'h0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset configuration: unused channels follow raw
    send_item(OP_POLL, 8'hA5, 8'h10, 8'h00, 4'h0);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'hFF, MODE_CAPTURE);
    drain();

    // one channel each of modes 1 to 5 and aux, a mode above aux on channel 6, release head 255
    load_config(32'h0F85_4321, 64'h1716_1514_13FF_1110, 64'hEEEE_EEEE_EEEE_21EE,
                24'h000018, 16'd5, 16'd20, 16'd10);
    send_item(OP_POLL, 8'h00, 8'h00, 8'h00, 4'h0);
    send_item(OP_POLL, 8'hFF, 8'h00, 8'h00, 4'h0);
    send_item(OP_POLL, 8'hFF, 8'h06, 8'h00, 4'h0);
    send_item(OP_POLL, 8'hFF, 8'hFF, 8'h00, 4'h0);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h10, MODE_CAPTURE);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h11, MODE_TCAPTURE);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h21, MODE_CAPTURE);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'hFF, MODE_RELEASE);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h14, MODE_OVL_G);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h15, MODE_AUX);
    send_item(OP_ACK, 8'h00, 8'h00, 8'h10, MODE_CAPTURE);
    send_item(OP_ACK, 8'h00, 8'h00, 8'h21, MODE_TCAPTURE);
    send_item(OP_ACK, 8'h00, 8'h00, 8'hFF, MODE_RELEASE);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'h10, MODE_CAPTURE);
    send_item(OP_POLL, 8'h00, 8'h00, 8'h00, 4'h0);
    send_item(OP_POLL, 8'h00, 8'hFF, 8'h00, 4'h0);
    send_item(OP_FORCE, 8'h00, 8'h00, 8'h10, MODE_TCAPTURE);
    send_item(OP_FORCE, 8'h00, 8'h00, 8'hFF, MODE_RELEASE);
    send_item(OP_FORCE, 8'h00, 8'h00, 8'h16, MODE_TURNOUT);
    send_item(OP_ACK, 8'h00, 8'h00, 8'h16, 4'hF);
    send_item(OP_QUERY, 8'h00, 8'h00, 8'hFF, MODE_RELEASE);
    send_item(OP_QUERY, 8'hFF, 8'hFF, 8'h00, MODE_UNUSED);
    send_item(OP_POLL, 8'h5A, 8'hFF, 8'h00, 4'h0);
    drain();

    // random phases across delay extremes and mode mixes
    random_phase(40, 0, 1'b1);
    random_phase(40, 1, 1'b0);
    random_phase(40, 2, 1'b0);
    random_phase(40, 2, 1'b1);
    quiet = 1'b1;
    random_phase(40, 2, 1'b0);
    drain();

    // long stable raw with delays just under the ceiling
    load_config(32'h8765_4321, 64'h0706_0504_0302_0100, {64{1'b1}}, 24'h000018,
                16'hFFFE, 16'hFFFE, 16'hFFFE);
    send_item(OP_POLL, 8'h05, 8'h00, 8'h00, 4'h0);
    send_item(OP_POLL, 8'hFA, 8'h00, 8'h00, 4'h0);
    send_item(OP_FORCE, 8'h00, 8'h00, 8'h00, MODE_CAPTURE);
    send_item(OP_ACK, 8'h00, 8'h00, 8'h00, MODE_CAPTURE);
    send_item(OP_FORCE, 8'h00, 8'h00, 8'h02, MODE_RELEASE);
    for (int k = 0; k < 20; k++) begin
      if (k == 10) send_item(OP_QUERY, 8'h00, 8'h00, 8'h02, MODE_RELEASE);
      send_item(OP_POLL, 8'hFA, 8'hFF, 8'h00, 4'h0);
    end
    quiet = 1'b0;
    drain();
    repeat (16) @(posedge clk);

    if (sb.due_results.size() != 0) sb.report("results still expected at end of run");
    if (sb.errors == 0) begin
      $display("latched_input_qualifier_8ch test passed");
    end else begin
      $display("latched_input_qualifier_8ch test failed");
    end
    $finish;
  end

endmodule
